>>> rtl/rocec_pkg.sv
// Shared types and constants for the rectilinear outline edge checker.
package rocec_pkg;

  // Width of each coordinate field on the input bus.
  localparam int FIELD_WIDTH         = 32;
  // Default coordinate width used for the comparisons.
  localparam int COORD_WIDTH_DEFAULT = 32;
  // Input bus: start_x, start_y, end_x, end_y.
  localparam int IN_TDATA_W          = 4 * FIELD_WIDTH;
  // Output bus: direction (2), error_code (3), outline_failed (1), pad.
  localparam int OUT_TDATA_W         = 8;
  localparam int OUT_PAD_W           = OUT_TDATA_W - 6;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_CONT  = 3'd1,
    ERR_ZERO  = 3'd2,
    ERR_ORTHO = 3'd3,
    ERR_REV   = 3'd4
  } err_t;

  // Heading: a direction in the low bits, or the start code (no direction yet).
  localparam logic [2:0] HEAD_START = 3'd4;

  typedef struct packed {
    logic ok;
    dir_t dir;
    err_t err;
  } chk_result_t;

endpackage

>>> rtl/rocec_check.sv
// Edge check: continuity, length, orthogonality, direction and reversal.
module rocec_check #(
  parameter int CW = rocec_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                  first,
  input  logic signed [CW-1:0]  px,
  input  logic signed [CW-1:0]  py,
  input  logic signed [CW-1:0]  qx,
  input  logic signed [CW-1:0]  qy,
  input  logic signed [CW-1:0]  prev_x,
  input  logic signed [CW-1:0]  prev_y,
  input  logic [2:0]            heading,
  output rocec_pkg::chk_result_t result
);

  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;
  logic [2:0]           bh;
  logic                 cont_err;
  logic                 zero_err;
  logic                 ortho_err;
  logic                 rev_err;
  rocec_pkg::dir_t      dir;

  // A first edge restarts the outline from its own start point.
  assign bx = first ? px : prev_x;
  assign by = first ? py : prev_y;
  assign bh = first ? rocec_pkg::HEAD_START : heading;

  assign cont_err  = (px != bx) || (py != by);
  assign zero_err  = (qx == bx) && (qy == by);
  assign ortho_err = (qx != bx) && (qy != by);

  always_comb begin
    if (qx == bx) begin
      dir = (qy < by) ? rocec_pkg::DIR_DOWN : rocec_pkg::DIR_UP;
    end else begin
      dir = (qx < bx) ? rocec_pkg::DIR_LEFT : rocec_pkg::DIR_RIGHT;
    end
  end

  // Opposite direction codes are bitwise complements.
  assign rev_err = (bh != rocec_pkg::HEAD_START) && (dir == rocec_pkg::dir_t'(~bh[1:0]));

  always_comb begin
    result.ok  = 1'b0;
    result.dir = rocec_pkg::DIR_UP;
    if (cont_err) begin
      result.err = rocec_pkg::ERR_CONT;
    end else if (zero_err) begin
      result.err = rocec_pkg::ERR_ZERO;
    end else if (ortho_err) begin
      result.err = rocec_pkg::ERR_ORTHO;
    end else if (rev_err) begin
      result.err = rocec_pkg::ERR_REV;
    end else begin
      result.err = rocec_pkg::ERR_OK;
      result.ok  = 1'b1;
      result.dir = dir;
    end
  end

endmodule

>>> rtl/rectilinear_outline_edge_checker_unit.sv
// Top level of the rectilinear outline edge checker: stream in, checks, stream out.
// Pipeline: two register stages, input register then result register, from s_tdata
//   to m_tdata.
// Throughput: one edge per cycle while m_tready is high; the stored point and heading
//   are updated in the same cycle as the check, so consecutive edges follow back to back.
// Reset (rst, synchronous, active high): clears valids, point to (0,0), heading to start,
//   failure flag and winding mode.
module rectilinear_outline_edge_checker_unit #(
  parameter int COORD_WIDTH = rocec_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Winding mode register: 0 clockwise, 1 counter-clockwise.
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  // Edge requests.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata, from bit 0: start_x[31:0], start_y[31:0], end_x[31:0], end_y[31:0]
  input  logic [rocec_pkg::IN_TDATA_W-1:0]   s_tdata,
  // tuser: first_edge
  input  logic                               s_tuser,
  // Results.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata, from bit 0: direction[1:0], error_code[2:0], outline_failed, 2 zero bits
  output logic [rocec_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // Only the low coordinate bits take part, at most one whole field.
  localparam int CW = (COORD_WIDTH < rocec_pkg::FIELD_WIDTH) ? COORD_WIDTH
                                                             : rocec_pkg::FIELD_WIDTH;
  localparam int FW = rocec_pkg::FIELD_WIDTH;

  // Configuration.
  logic winding_mode;

  // Input register stage.
  logic                 in_valid;
  logic                 in_first;
  logic signed [CW-1:0] in_ax;
  logic signed [CW-1:0] in_ay;
  logic signed [CW-1:0] in_bx;
  logic signed [CW-1:0] in_by;

  // Outline state.
  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;
  logic [2:0]           heading;
  logic                 failure_flag;
  logic                 failure_flag_next;

  // Result register stage.
  logic                 out_valid;
  rocec_pkg::dir_t      out_dir;
  rocec_pkg::err_t      out_err;
  logic                 out_failed;

  // Traversal points after winding selection.
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;

  rocec_pkg::chk_result_t chk;
  logic                   advance;

  // Move the held edge into the result register whenever the result slot is free
  // or being emptied this cycle; take a new request whenever the input slot frees.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      winding_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      winding_mode <= cfg_wr_data;
    end
  end

  // Input register: hold the request until the check stage takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_first <= s_tuser;
      in_ax    <= s_tdata[0*FW +: CW];
      in_ay    <= s_tdata[1*FW +: CW];
      in_bx    <= s_tdata[2*FW +: CW];
      in_by    <= s_tdata[3*FW +: CW];
    end
  end

  // Counter-clockwise traversal runs from the end point back to the start point.
  assign px = winding_mode ? in_bx : in_ax;
  assign py = winding_mode ? in_by : in_ay;
  assign qx = winding_mode ? in_ax : in_bx;
  assign qy = winding_mode ? in_ay : in_by;

  rocec_check #(
    .CW (CW)
  ) u_check (
    .first   (in_first),
    .px      (px),
    .py      (py),
    .qx      (qx),
    .qy      (qy),
    .prev_x  (prev_x),
    .prev_y  (prev_y),
    .heading (heading),
    .result  (chk)
  );

  assign failure_flag_next = failure_flag || !chk.ok;

  // Outline state: advance to the end point on a good edge; on a rejected first
  // edge still restart from its start point with no heading.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      heading      <= rocec_pkg::HEAD_START;
      failure_flag <= 1'b0;
    end else if (advance) begin
      failure_flag <= failure_flag_next;
      if (chk.ok) begin
        prev_x  <= qx;
        prev_y  <= qy;
        heading <= {1'b0, chk.dir};
      end else if (in_first) begin
        prev_x  <= px;
        prev_y  <= py;
        heading <= rocec_pkg::HEAD_START;
      end
    end
  end

  // Result register: hold until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dir    <= chk.dir;
      out_err    <= chk.err;
      out_failed <= failure_flag_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{rocec_pkg::OUT_PAD_W{1'b0}}, out_failed, out_err, out_dir};

`ifndef ASSERT_OFF
  // A rejected edge reports no direction and always shows the failure flag.
  a_err_clean : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err != rocec_pkg::ERR_OK) |-> (out_dir == rocec_pkg::DIR_UP && out_failed))
    else $error("error result carries a direction or a clear failure flag");

  // Once set, the failure flag stays set until reset.
  a_fail_sticky : assert property (@(posedge clk) disable iff (rst)
    (!rst && failure_flag) |=> failure_flag)
    else $error("failure flag dropped without reset");

  // Point and heading move only when an edge passes through the check stage.
  a_state_hold : assert property (@(posedge clk) disable iff (rst)
    (!rst && !advance) |=> ($stable(heading) && $stable(prev_x) && $stable(prev_y)))
    else $error("outline state changed with no edge checked");

  // A good edge leaves its direction as the heading.
  a_heading_follows : assert property (@(posedge clk) disable iff (rst)
    (!rst && advance && chk.ok) |=> (heading == {1'b0, out_dir}))
    else $error("heading does not follow the accepted direction");
`endif

endmodule
